// ===== sv/i2d_pkg.sv =====
// ----------------------------------------------------------------------------
// i2d_pkg
// Shared constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2d_pkg;

    localparam int NUM_W      = 32;
    localparam int CHAR_W     = 6;
    localparam int LEN_W      = 4;
    localparam int DIGIT_W    = 4;
    localparam int DIGITS_MAX = 10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;

    // x / 10 == (x * RECIP_10) >> RECIP_SHIFT for every 32-bit x
    localparam logic [NUM_W-1:0] RECIP_10    = 32'hCCCC_CCCD;
    localparam int               RECIP_SHIFT = 35;
    localparam int               PROD_W      = 2 * NUM_W;
    localparam int               QUOT_W      = PROD_W - RECIP_SHIFT;

endpackage

// ===== sv/i2d_div10.sv =====
// ----------------------------------------------------------------------------
// i2d_div10
// Divide-by-ten unit: registered reciprocal product, then quotient and
// remainder. Result is valid in the cycle after the dividend is presented,
// with the dividend held steady.
// ----------------------------------------------------------------------------
module i2d_div10
    import i2d_pkg::*;
(
    input  logic               clk,
    input  logic [NUM_W-1:0]   dividend,
    output logic [NUM_W-1:0]   quotient,
    output logic [DIGIT_W-1:0] remainder
);

    logic [PROD_W-1:0] prod_reg;
    logic [QUOT_W-1:0] quot_short;
    logic [NUM_W-1:0]  quot_x10;
    logic [NUM_W-1:0]  diff;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(dividend) * PROD_W'(RECIP_10);
    end

    assign quot_short = prod_reg[PROD_W-1:RECIP_SHIFT];
    assign quotient   = NUM_W'(quot_short);
    assign quot_x10   = (quotient << 3) + (quotient << 1);
    assign diff       = dividend - quot_x10;
    assign remainder  = diff[DIGIT_W-1:0];

endmodule

// ===== sv/int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Converts a signed 32-bit integer to its decimal ASCII text.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: number_in with valid/ready. A request is taken only when
//   the converter is idle; ready stays low while a number is being divided
//   or its text emitted. Output channel: text_char, text_length, is_last
//   with valid/ready, one request per character, most significant first,
//   '-' leading a negative value. is_last marks the final character.
//   Operation: digits come from repeated division by ten in one shared unit
//   (registered reciprocal multiply, then quotient/remainder), one S_MUL and
//   one S_DIV state per digit; the characters then follow, one per cycle
//   while the receiver is ready. A number has up to ten digits and a sign.
//   The converter returns to idle once the last character is loaded.
//   The output register lets the next number be accepted while the last
//   character of the previous one still waits.
//   Reset clears all control state; no character is offered after reset.
//   A stalled receiver holds the current character and pauses emission.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii
    import i2d_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [NUM_W-1:0]  number_in,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [CHAR_W-1:0] text_char,
    output logic [LEN_W-1:0]  text_length,
    output logic              is_last
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_EMIT = 2'd3;

    logic [1:0]         state_reg;
    logic [NUM_W-1:0]   mag_reg;
    logic               neg_reg;
    logic               sign_pend_reg;
    logic [LEN_W-1:0]   ndig_reg;
    logic [LEN_W-1:0]   dig_idx_reg;
    logic [DIGIT_W-1:0] digit_reg [DIGITS_MAX];

    logic               out_valid_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               last_reg;

    logic [NUM_W-1:0]   quotient;
    logic [DIGIT_W-1:0] remainder;
    logic               in_fire;
    logic               out_fire;
    logic               load;

    i2d_div10 u_div10 (
        .clk       (clk),
        .dividend  (mag_reg),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid_reg && out_ready;
    assign load     = (state_reg == S_EMIT) && (!out_valid_reg || out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            ndig_reg      <= '0;
            dig_idx_reg   <= '0;
            sign_pend_reg <= 1'b0;
        end
        else
        begin
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        ndig_reg  <= '0;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    ndig_reg <= ndig_reg + 1'b1;
                    if (quotient == '0)
                    begin
                        dig_idx_reg   <= ndig_reg;
                        sign_pend_reg <= neg_reg;
                        state_reg     <= S_EMIT;
                    end
                    else
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_EMIT:
                begin
                    if (load)
                    begin
                        if (sign_pend_reg)
                            sign_pend_reg <= 1'b0;
                        else if (dig_idx_reg == '0)
                            state_reg <= S_IDLE;
                        else
                            dig_idx_reg <= dig_idx_reg - 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            neg_reg <= number_in[NUM_W-1];
            mag_reg <= number_in[NUM_W-1] ? (NUM_W'(0) - number_in) : number_in;
        end
        else if (state_reg == S_DIV)
        begin
            mag_reg                                <= quotient;
            digit_reg[ndig_reg[DIGIT_W-1:0]]       <= remainder;
        end

        if (load)
        begin
            len_reg <= ndig_reg + LEN_W'(neg_reg);
            if (sign_pend_reg)
            begin
                char_reg <= CHAR_MINUS;
                last_reg <= 1'b0;
            end
            else
            begin
                char_reg <= CHAR_ZERO + CHAR_W'(digit_reg[dig_idx_reg[DIGIT_W-1:0]]);
                last_reg <= (dig_idx_reg == '0);
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign text_char   = char_reg;
    assign text_length = len_reg;
    assign is_last     = last_reg;

`ifndef SYNTHESIS
    a_accept_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_MUL))
        else $error("accepted request did not start division");

    a_mid_text_emitting: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && !is_last) |-> (state_reg == S_EMIT))
        else $error("text ended without a last character");

    a_emit_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (ndig_reg != '0 && dig_idx_reg < ndig_reg))
        else $error("emission without digits");

    a_len_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (text_length != '0 && text_length <= LEN_W'(DIGITS_MAX + 1)))
        else $error("text length out of range");
`endif

endmodule
